// ===== src/dtt_pkg.sv =====
// Package for the deadline timer table: payload structs, function codes,
// result kinds and the sequencer state type. No dependencies.
`default_nettype none
package dtt_pkg;
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned ID_W = 32;
    localparam int unsigned DUR_W = 32;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 5;
    localparam int unsigned MAX_ACT_W = 5;
    localparam int unsigned OUT_MAX = 16;

    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_END    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_REPLY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACTIVE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_ON = 1'd1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   op_id;
        logic [DUR_W-1:0]  duration_ms;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   result_id;
        logic [TIME_W-1:0] remaining_ms;
        logic              past_due;
        logic              is_cancel;
        logic              found;
        logic              last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_APPLY,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT,
        ST_SEND
    } state_t;
endpackage
`default_nettype wire

// ===== src/deadline_timer_table_top.sv =====
// Deadline timer table top level: slot memory, shared slot walker and
// sequencer in one module. Depends on dtt_pkg.
//
//  channel | dir | ports                     | handshake
//  request | in  | s_valid s_ready s_data    | valid/ready
//  result  | out | m_valid m_ready m_data    | valid/ready
//  config  | in  | cfg_we cfg_index cfg_data | write enable, no wait
//
// Start, update, cancel and end pass through the accept cycle, a walk of one slot per
// cycle through one id compare unit, the apply step and the send step before the next
// request is taken. A query adds an emit step to read the deadline.
// A tick without a scan is taken in its accept cycle. A scanning tick walks every slot,
// then a flush step sends the held event, if any, as the last result.
// A waiting result holds the sequencer; in a scan the walk stops only when a second
// expired slot is found while one event is still held. Reset is synchronous.
`default_nettype none
module deadline_timer_table_top #(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned PERIOD = 100
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire dtt_pkg::req_t                  s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output dtt_pkg::rsp_t                       m_data,
    input  wire logic                           cfg_we,
    input  wire logic [dtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dtt_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam int unsigned SCAN_W = $clog2(PERIOD + 1);

    logic [dtt_pkg::ID_W-1:0]   id_mem [ENTRIES];
    logic [dtt_pkg::TIME_W-1:0] dl_mem [ENTRIES];
    logic [ENTRIES-1:0]         valid_reg, valid_next;
    logic [ENTRIES-1:0]         canc_reg;

    dtt_pkg::state_t state_reg, state_next;
    dtt_pkg::req_t   req_reg;
    dtt_pkg::rsp_t   out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic            hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [dtt_pkg::ID_W-1:0] next_id_reg, next_id_next;
    logic [dtt_pkg::TIME_W-1:0] clock_reg, clock_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [dtt_pkg::MAX_ACT_W-1:0] max_active_reg;
    logic            wd_reg;

    // The scan keeps one event held back so that the final one can carry last.
    logic                       pend_reg, pend_next;
    logic [dtt_pkg::ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [CNT_W-1:0]           evt_cnt_reg, evt_cnt_next;

    logic [dtt_pkg::ID_W-1:0]   rd_id_reg;
    logic [dtt_pkg::TIME_W-1:0] rd_dl_reg;
    logic [dtt_pkg::TIME_W:0]   dl_sum;
    logic [dtt_pkg::TIME_W-1:0] new_dl;
    logic            wr_en, wr_id_en;
    logic [IDX_W-1:0] wr_idx;
    logic            canc_set;
    logic            last_idx, out_free, expired_here, take;

    assign dl_sum = {1'b0, clock_reg} + {{(dtt_pkg::TIME_W + 1 - dtt_pkg::DUR_W){1'b0}},
                                         req_reg.duration_ms};
    assign new_dl = dl_sum[dtt_pkg::TIME_W] ? dtt_pkg::TIME_MAX
                                            : dl_sum[dtt_pkg::TIME_W-1:0];
    assign last_idx = (idx_reg == IDX_W'(ENTRIES - 1));
    assign out_free = !out_valid_reg || m_ready;
    assign expired_here = valid_reg[idx_reg] && !canc_reg[idx_reg] && (clock_reg > rd_dl_reg);
    assign take = expired_here && (32'(evt_cnt_reg) < dtt_pkg::OUT_MAX);

    assign s_ready = (state_reg == dtt_pkg::ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dl_mem[wr_idx] <= new_dl;
        end
        if (wr_id_en) begin
            id_mem[wr_idx] <= next_id_reg;
        end
        rd_id_reg <= id_mem[idx_next];
        rd_dl_reg <= dl_mem[idx_next];
        if (wr_id_en) begin
            canc_reg[wr_idx] <= 1'b0;
        end else if (canc_set) begin
            canc_reg[wr_idx] <= 1'b1;
        end
        out_reg <= out_next;
        pend_id_reg <= pend_id_next;
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dtt_pkg::ST_IDLE;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            live_reg <= '0;
            hit_reg <= 1'b0;
            hit_idx_reg <= '0;
            next_id_reg <= 32'd1;
            clock_reg <= '0;
            scan_reg <= '0;
            max_active_reg <= 5'd16;
            wd_reg <= 1'b0;
            pend_reg <= 1'b0;
            evt_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
            live_reg <= live_next;
            hit_reg <= hit_next;
            hit_idx_reg <= hit_idx_next;
            next_id_reg <= next_id_next;
            clock_reg <= clock_next;
            scan_reg <= scan_next;
            pend_reg <= pend_next;
            evt_cnt_reg <= evt_cnt_next;
            if (cfg_we && cfg_index == dtt_pkg::CFG_MAX_ACTIVE) begin
                max_active_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == dtt_pkg::CFG_WATCHDOG_ON) begin
                wd_reg <= cfg_data[0];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        idx_next = idx_reg;
        live_next = live_reg;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        next_id_next = next_id_reg;
        clock_next = clock_reg;
        scan_next = scan_reg;
        pend_next = pend_reg;
        pend_id_next = pend_id_reg;
        evt_cnt_next = evt_cnt_reg;
        wr_en = 1'b0;
        wr_id_en = 1'b0;
        wr_idx = hit_idx_reg;
        canc_set = 1'b0;
        case (state_reg)
            dtt_pkg::ST_IDLE: begin
                idx_next = '0;
                live_next = '0;
                hit_next = 1'b0;
                hit_idx_next = '0;
                pend_next = 1'b0;
                evt_cnt_next = '0;
                if (s_valid) begin
                    if (s_data.func == dtt_pkg::FUNC_TICK) begin
                        if (clock_reg != dtt_pkg::TIME_MAX) begin
                            clock_next = clock_reg + 1'b1;
                        end
                        if (wd_reg) begin
                            if (scan_reg + 1'b1 >= SCAN_W'(PERIOD)) begin
                                scan_next = '0;
                                state_next = dtt_pkg::ST_SCAN;
                            end else begin
                                scan_next = scan_reg + 1'b1;
                            end
                        end
                    end else if (s_data.func <= dtt_pkg::FUNC_QUERY) begin
                        state_next = dtt_pkg::ST_WALK;
                    end
                end
            end
            dtt_pkg::ST_WALK: begin
                if (req_reg.func == dtt_pkg::FUNC_START) begin
                    if (valid_reg[idx_reg]) begin
                        live_next = live_reg + 1'b1;
                    end else if (!hit_reg) begin
                        hit_next = 1'b1;
                        hit_idx_next = idx_reg;
                    end
                end else if (!hit_reg && valid_reg[idx_reg] && rd_id_reg == req_reg.op_id) begin
                    hit_next = 1'b1;
                    hit_idx_next = idx_reg;
                end
                idx_next = idx_reg + 1'b1;
                if (last_idx) begin
                    idx_next = '0;
                    state_next = dtt_pkg::ST_APPLY;
                end
            end
            dtt_pkg::ST_APPLY: begin
                idx_next = hit_idx_reg;
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next.last = 1'b1;
                    out_next.result_id = req_reg.op_id;
                    out_next.found = hit_reg;
                    state_next = dtt_pkg::ST_SEND;
                    case (req_reg.func)
                        dtt_pkg::FUNC_START: begin
                            if (hit_reg && (32'(live_reg) < 32'(max_active_reg))) begin
                                out_next.result_id = next_id_reg;
                                wr_en = 1'b1;
                                wr_id_en = 1'b1;
                                valid_next[hit_idx_reg] = 1'b1;
                                next_id_next = (next_id_reg == '1) ? 32'd1 : next_id_reg + 1'b1;
                            end else begin
                                out_next.result_id = '0;
                                out_next.found = 1'b0;
                            end
                        end
                        dtt_pkg::FUNC_UPDATE: begin
                            wr_en = hit_reg;
                        end
                        dtt_pkg::FUNC_CANCEL: begin
                            if (hit_reg) begin
                                canc_set = 1'b1;
                                out_next.kind = dtt_pkg::KIND_CANCELED;
                            end
                        end
                        dtt_pkg::FUNC_END: begin
                            if (hit_reg) begin
                                valid_next[hit_idx_reg] = 1'b0;
                            end
                        end
                        dtt_pkg::FUNC_QUERY: begin
                            out_valid_next = 1'b0;
                            state_next = dtt_pkg::ST_EMIT;
                        end
                        default: begin
                            out_valid_next = 1'b0;
                            state_next = dtt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            dtt_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next.last = 1'b1;
                    out_next.result_id = req_reg.op_id;
                    if (hit_reg) begin
                        out_next.found = 1'b1;
                        out_next.remaining_ms = (rd_dl_reg > clock_reg) ? rd_dl_reg - clock_reg
                                                                        : '0;
                        out_next.past_due = clock_reg > rd_dl_reg;
                        out_next.is_cancel = canc_reg[idx_reg];
                    end else begin
                        out_next.is_cancel = 1'b1;
                    end
                    state_next = dtt_pkg::ST_SEND;
                end
            end
            dtt_pkg::ST_SCAN: begin
                if (!(take && pend_reg) || out_free) begin
                    if (take) begin
                        pend_next = 1'b1;
                        pend_id_next = rd_id_reg;
                        evt_cnt_next = evt_cnt_reg + 1'b1;
                        if (pend_reg) begin
                            out_valid_next = 1'b1;
                            out_next = '0;
                            out_next.kind = dtt_pkg::KIND_TIMEOUT;
                            out_next.result_id = pend_id_reg;
                            out_next.found = 1'b1;
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                    if (last_idx) begin
                        idx_next = '0;
                        state_next = dtt_pkg::ST_FLUSH;
                    end
                end
            end
            dtt_pkg::ST_FLUSH: begin
                if (!pend_reg) begin
                    state_next = dtt_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next.kind = dtt_pkg::KIND_TIMEOUT;
                    out_next.result_id = pend_id_reg;
                    out_next.found = 1'b1;
                    out_next.last = 1'b1;
                    pend_next = 1'b0;
                    state_next = dtt_pkg::ST_SEND;
                end
            end
            dtt_pkg::ST_SEND: begin
                if (m_ready) begin
                    state_next = dtt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dtt_pkg::ST_IDLE;
            end
        endcase
        if (cfg_we && cfg_index == dtt_pkg::CFG_WATCHDOG_ON && !cfg_data[0]) begin
            scan_next = '0;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == dtt_pkg::ST_IDLE))
        else $error("ready outside idle");
    a_send_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dtt_pkg::ST_SEND) |-> out_valid_reg)
        else $error("send state without result");
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CNT_W'(ENTRIES))
        else $error("live count overflow");
    a_pend_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == dtt_pkg::ST_SCAN || state_reg == dtt_pkg::ST_FLUSH))
        else $error("held event outside a scan");
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while waiting");
endmodule
`default_nettype wire
